[rtl/ssm_pkg.sv]
`timescale 1ns / 1ps

package ssm_pkg;

    // Sizing
    localparam int WORDS_PER_BEAT = 16;
    localparam int MAX_BEATS      = 4096;
    localparam int BEATS_W        = 13;
    localparam int WORD_W         = 32;
    // word counters hold 0 .. MAX_BEATS * WORDS_PER_BEAT
    localparam int COUNT_W        = $clog2(MAX_BEATS * WORDS_PER_BEAT + 1);

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream packing
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    localparam logic [0:0] REG_LIST_ONE = 1'b0;
    localparam logic [0:0] REG_LIST_TWO = 1'b1;

    // List selector
    localparam logic LIST_ONE = 1'b0;
    localparam logic LIST_TWO = 1'b1;

    // Result status
    localparam logic STATUS_EMIT   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Wanted list codes
    localparam logic [1:0] WANT_ONE  = 2'd0;
    localparam logic [1:0] WANT_TWO  = 2'd1;
    localparam logic [1:0] WANT_NONE = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] merged_value;
        logic              from_list;
        logic              final_word;
        logic              status;
        logic [1:0]        wanted_list;
    } result_t;

    // Results produced by one accepted transaction: zero, one or two
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

[rtl/sorted_stream_merge.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata word_value, tuser source_list
// m_axis    out  m_axis_tvalid/tready        tdata merged_value + wanted_list,
//                                            tuser from_list + status, tlast final_word
// cfg       in   cfg_we (no wait)            cfg_index, cfg_data (list length in beats)
//
// One input transaction per cycle while the queue has room. The merge step (one
// 32-bit head compare and the length checks) runs between the head registers and
// a four-entry result queue; a transaction yields zero, one or two results.
// s_axis_tready is high while the queue has at least two free entries, so throughput is
// set by the output port draining one result per cycle while m_axis_tready is high.
// Reset empties the heads and clears lengths and counters; the queue comes up empty.
// A stalled m_axis holds its result; new words are taken while two queue entries stay free.

module sorted_stream_merge
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [ssm_pkg::BEATS_W-1:0]     cfg_data,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ssm_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] word_value
    input  logic [0:0]                      s_axis_tuser,   // [0] source_list

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ssm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] merged_value,
                                                            // [33:32] wanted_list, rest 0
    output logic [1:0]                      m_axis_tuser,   // [0] from_list, [1] status
    output logic                            m_axis_tlast    // final_word
);

    ssm_pkg::step_out_t step;
    ssm_pkg::result_t   res;
    logic               room;
    logic               in_fire;

    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && room;

    ssm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_src    (s_axis_tuser[0]),
        .in_word   (s_axis_tdata[ssm_pkg::WORD_W-1:0]),
        .step      (step)
    );

    ssm_result_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {6'd0, res.wanted_list, res.merged_value};
    assign m_axis_tuser = {res.status, res.from_list};
    assign m_axis_tlast = res.final_word;

endmodule

[rtl/ssm_core.sv]
`timescale 1ns / 1ps

module ssm_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [ssm_pkg::BEATS_W-1:0]  cfg_data,
    input  logic                         in_fire,
    input  logic                         in_src,
    input  logic [ssm_pkg::WORD_W-1:0]   in_word,
    output ssm_pkg::step_out_t           step
);

    logic [ssm_pkg::COUNT_W-1:0] total_one_reg, total_two_reg, cfg_total;
    logic                        head_one_full_reg, head_two_full_reg;
    logic [ssm_pkg::WORD_W-1:0]  head_one_value_reg, head_two_value_reg;
    logic [ssm_pkg::COUNT_W-1:0] taken_one_reg, taken_two_reg;

    logic                        head_one_full_next, head_two_full_next;
    logic [ssm_pkg::WORD_W-1:0]  head_one_value_next, head_two_value_next;
    logic [ssm_pkg::COUNT_W-1:0] taken_one_next, taken_two_next;
    logic                        commit;

    // {emit, from}
    function automatic logic [1:0] pick(input logic f1, input logic f2,
                                        input logic [ssm_pkg::WORD_W-1:0] v1,
                                        input logic [ssm_pkg::WORD_W-1:0] v2,
                                        input logic done1, input logic done2);
        logic [1:0] r;
        r = {1'b0, ssm_pkg::LIST_ONE};
        if (f1 && f2)
            r = {1'b1, (v1 <= v2) ? ssm_pkg::LIST_ONE : ssm_pkg::LIST_TWO};
        else if (f1 && done2)
            r = {1'b1, ssm_pkg::LIST_ONE};
        else if (f2 && done1)
            r = {1'b1, ssm_pkg::LIST_TWO};
        return r;
    endfunction

    function automatic logic [1:0] wanted(input logic f1, input logic need_room1,
                                          input logic f2, input logic need_room2);
        logic [1:0] w;
        if (!f1 && need_room1)
            w = ssm_pkg::WANT_ONE;
        else if (!f2 && need_room2)
            w = ssm_pkg::WANT_TWO;
        else
            w = ssm_pkg::WANT_NONE;
        return w;
    endfunction

    // Length in words, oversized lengths clamp to the maximum
    always_comb
    begin
        logic [31:0] beats;
        beats = 32'(cfg_data);
        if (beats > 32'(ssm_pkg::MAX_BEATS))
            beats = 32'(ssm_pkg::MAX_BEATS);
        cfg_total = ssm_pkg::COUNT_W'(beats * 32'(ssm_pkg::WORDS_PER_BEAT));
    end

    always_comb
    begin
        logic                        need_one, need_two, ok;
        logic                        f1, f2;
        logic [ssm_pkg::WORD_W-1:0]  v1, v2;
        logic [ssm_pkg::COUNT_W-1:0] t1, t2;
        logic [1:0]                  sel0, sel1, w_now, w_after;
        logic [ssm_pkg::WORD_W-1:0]  val0, val1;
        logic                        fin0, fin1;

        need_one = !head_one_full_reg && (taken_one_reg < total_one_reg);
        need_two = !head_two_full_reg && (taken_two_reg < total_two_reg);
        ok = (in_src == ssm_pkg::LIST_TWO) ? need_two : need_one;
        w_now = wanted(head_one_full_reg, taken_one_reg < total_one_reg,
                       head_two_full_reg, taken_two_reg < total_two_reg);

        // load the arriving word into its head
        f1 = head_one_full_reg || (in_src == ssm_pkg::LIST_ONE);
        f2 = head_two_full_reg || (in_src == ssm_pkg::LIST_TWO);
        v1 = (in_src == ssm_pkg::LIST_ONE) ? in_word : head_one_value_reg;
        v2 = (in_src == ssm_pkg::LIST_TWO) ? in_word : head_two_value_reg;
        t1 = taken_one_reg;
        t2 = taken_two_reg;

        // first emission
        sel0 = pick(f1, f2, v1, v2, t1 >= total_one_reg, t2 >= total_two_reg);
        val0 = (sel0[0] == ssm_pkg::LIST_ONE) ? v1 : v2;
        if (sel0[1])
        begin
            if (sel0[0] == ssm_pkg::LIST_ONE)
            begin
                f1 = 1'b0;
                t1 = t1 + 1'b1;
            end
            else
            begin
                f2 = 1'b0;
                t2 = t2 + 1'b1;
            end
        end
        fin0 = !f1 && !f2 && (t1 >= total_one_reg) && (t2 >= total_two_reg);

        // second emission: one list ended while the other head waits
        sel1 = {1'b0, ssm_pkg::LIST_ONE};
        if (sel0[1])
            sel1 = pick(f1, f2, v1, v2, t1 >= total_one_reg, t2 >= total_two_reg);
        val1 = (sel1[0] == ssm_pkg::LIST_ONE) ? v1 : v2;
        if (sel1[1])
        begin
            if (sel1[0] == ssm_pkg::LIST_ONE)
            begin
                f1 = 1'b0;
                t1 = t1 + 1'b1;
            end
            else
            begin
                f2 = 1'b0;
                t2 = t2 + 1'b1;
            end
        end
        fin1 = !f1 && !f2 && (t1 >= total_one_reg) && (t2 >= total_two_reg);

        w_after = wanted(f1, t1 < total_one_reg, f2, t2 < total_two_reg);

        commit = in_fire && ok;
        head_one_full_next  = f1;
        head_two_full_next  = f2;
        head_one_value_next = v1;
        head_two_value_next = v2;
        taken_one_next      = t1;
        taken_two_next      = t2;

        step = '0;
        if (in_fire && !ok)
        begin
            step.count              = 2'd1;
            step.first.status       = ssm_pkg::STATUS_REJECT;
            step.first.wanted_list  = w_now;
        end
        else if (in_fire)
        begin
            step.count               = 2'(sel0[1]) + 2'(sel1[1]);
            step.first.merged_value  = val0;
            step.first.from_list     = sel0[0];
            step.first.final_word    = fin0;
            step.first.status        = ssm_pkg::STATUS_EMIT;
            step.first.wanted_list   = w_after;
            step.second.merged_value = val1;
            step.second.from_list    = sel1[0];
            step.second.final_word   = fin1;
            step.second.status       = ssm_pkg::STATUS_EMIT;
            step.second.wanted_list  = w_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_one_reg     <= '0;
            total_two_reg     <= '0;
            head_one_full_reg <= 1'b0;
            head_two_full_reg <= 1'b0;
            taken_one_reg     <= '0;
            taken_two_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == ssm_pkg::REG_LIST_ONE)
                total_one_reg <= cfg_total;
            if (cfg_we && cfg_index == ssm_pkg::REG_LIST_TWO)
                total_two_reg <= cfg_total;
            if (commit)
            begin
                head_one_full_reg <= head_one_full_next;
                head_two_full_reg <= head_two_full_next;
                taken_one_reg     <= taken_one_next;
                taken_two_reg     <= taken_two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            head_one_value_reg <= head_one_value_next;
            head_two_value_reg <= head_two_value_next;
        end
    end

endmodule

[rtl/ssm_result_queue.sv]
`timescale 1ns / 1ps

module ssm_result_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssm_pkg::step_out_t step,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output ssm_pkg::result_t   out_result
);

    ssm_pkg::result_t           mem [ssm_pkg::QUEUE_DEPTH];
    logic [ssm_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [ssm_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       pop;
    logic [ssm_pkg::QPTR_W-1:0] wr_ptr_plus;

    // room for the largest burst of one transaction
    assign room        = count_reg <= ssm_pkg::QCNT_W'(ssm_pkg::QUEUE_DEPTH - 2);
    assign out_valid   = count_reg != '0;
    assign out_result  = mem[rd_ptr_reg];
    assign pop         = out_valid && out_ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ssm_pkg::QPTR_W'(step.count);
        rd_ptr_next = rd_ptr_reg + ssm_pkg::QPTR_W'(pop);
        count_next  = count_reg + ssm_pkg::QCNT_W'(step.count) - ssm_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0)
            mem[wr_ptr_reg] <= step.first;
        if (step.count == 2'd2)
            mem[wr_ptr_plus] <= step.second;
    end

endmodule

[rtl/ssm_checker.sv]
`timescale 1ns / 1ps

module ssm_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ssm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // a rejected transaction carries no word and never closes the merge
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] == ssm_pkg::STATUS_REJECT |->
            !m_axis_tlast && m_axis_tdata[31:0] == 32'd0 && !m_axis_tuser[0])
        else $error("rejected result carries data");

    // after the last merged word no list may be asked for
    a_last_wants_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[33:32] == ssm_pkg::WANT_NONE)
        else $error("final word still wants a list");

    // wanted code stays in range and padding stays zero
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3 && m_axis_tdata[39:34] == 6'd0)
        else $error("bad wanted code or padding");

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind sorted_stream_merge ssm_checker u_ssm_checker (.*);

[sim/sorted_stream_merge_tb.sv]
`timescale 1ns / 1ps

// Merge checker: a driver feeds words from a queue that the stimulus process fills, a
// monitor compares every merged transaction with the oldest predicted result. Prediction
// runs at the moment a word is accepted, on the testbench's own copy of the heads and
// counters. The stimulus process keeps a second copy of the same state so that it knows
// which list the block is asking for and can build well-formed ascending streams.

module sorted_stream_merge_tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1275;     // directed words plus about 1250 random ones
    localparam int PHASE_CAP    = 120;      // words per length setting
    localparam int DRAIN_CYCLES = 12;       // result queue plus merge stage, with margin
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PRINT_LIMIT  = 100;

    // Heads and counters of the merge, at the block's widths
    typedef struct packed {
        logic [ssm_pkg::BEATS_W-1:0] beats_one;
        logic [ssm_pkg::BEATS_W-1:0] beats_two;
        logic [ssm_pkg::WORD_W-1:0]  head_one;
        logic [ssm_pkg::WORD_W-1:0]  head_two;
        logic                        full_one;
        logic                        full_two;
        logic [ssm_pkg::COUNT_W-1:0] taken_one;
        logic [ssm_pkg::COUNT_W-1:0] taken_two;
    } merge_state_t;

    typedef struct packed {
        logic                       src;
        logic [ssm_pkg::WORD_W-1:0] word;
    } word_item_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [0:0]                      cfg_index     = ssm_pkg::REG_LIST_ONE;
    logic [ssm_pkg::BEATS_W-1:0]     cfg_data      = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ssm_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;   // [31:0] word_value
    logic [0:0]                      s_axis_tuser  = '0;   // [0] source_list
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ssm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;   // [31:0] merged_value, [33:32] wanted_list
    logic [1:0]                      m_axis_tuser;   // [0] from_list, [1] status
    logic                            m_axis_tlast;   // final_word

    merge_state_t       live_state;     // advanced on accepted transactions
    merge_state_t       plan_state;     // advanced as words are queued
    word_item_t         word_queue [$];
    ssm_pkg::result_t   expected_results [$];

    logic [ssm_pkg::WORD_W-1:0] last_one;
    logic [ssm_pkg::WORD_W-1:0] last_two;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int queued_count   = 0;
    int send_gap       = 0;
    int send_steady    = 0;
    int recv_hold      = 0;
    int recv_steady    = 0;

    sorted_stream_merge dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Merge predictor
    // ------------------------------------------------------------------

    // Words in a list; lengths above the maximum saturate
    function automatic int list_words(input logic [ssm_pkg::BEATS_W-1:0] beats);
        return ((beats > ssm_pkg::MAX_BEATS) ? ssm_pkg::MAX_BEATS : int'(beats))
               * ssm_pkg::WORDS_PER_BEAT;
    endfunction

    // List one wins when both heads are empty and both lists still have words
    function automatic logic [1:0] wanted_next(input merge_state_t st);
        if (!st.full_one && st.taken_one < list_words(st.beats_one))
            return ssm_pkg::WANT_ONE;
        if (!st.full_two && st.taken_two < list_words(st.beats_two))
            return ssm_pkg::WANT_TWO;
        return ssm_pkg::WANT_NONE;
    endfunction

    function automatic void merge_step(inout merge_state_t st, input logic src,
                                       input logic [ssm_pkg::WORD_W-1:0] word,
                                       output ssm_pkg::result_t res [2], output int n);
        int   total_one;
        int   total_two;
        logic pick;
        logic accept;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        total_one = list_words(st.beats_one);
        total_two = list_words(st.beats_two);
        accept = (src == ssm_pkg::LIST_ONE) ? (!st.full_one && st.taken_one < total_one)
                                            : (!st.full_two && st.taken_two < total_two);
        // Out of turn: occupied head or list already complete; state untouched
        if (!accept)
        begin
            res[0].status      = ssm_pkg::STATUS_REJECT;
            res[0].wanted_list = wanted_next(st);
            n = 1;
            return;
        end
        if (src == ssm_pkg::LIST_ONE)
        begin
            st.head_one = word;
            st.full_one = 1'b1;
        end
        else
        begin
            st.head_two = word;
            st.full_two = 1'b1;
        end
        // At most two words leave: the compare winner, then the other head when the
        // winner's list has just run out
        while (n < 2)
        begin
            if (st.full_one && st.full_two)
                pick = (st.head_one <= st.head_two) ? ssm_pkg::LIST_ONE : ssm_pkg::LIST_TWO;
            else if (st.full_one && st.taken_two >= total_two)
                pick = ssm_pkg::LIST_ONE;
            else if (st.full_two && st.taken_one >= total_one)
                pick = ssm_pkg::LIST_TWO;
            else
                break;
            res[n].status    = ssm_pkg::STATUS_EMIT;
            res[n].from_list = pick;
            if (pick == ssm_pkg::LIST_ONE)
            begin
                res[n].merged_value = st.head_one;
                st.full_one  = 1'b0;
                st.taken_one = st.taken_one + 1'b1;
            end
            else
            begin
                res[n].merged_value = st.head_two;
                st.full_two  = 1'b0;
                st.taken_two = st.taken_two + 1'b1;
            end
            res[n].final_word = !st.full_one && !st.full_two &&
                                st.taken_one >= total_one && st.taken_two >= total_two;
            n++;
        end
        // wanted_list reflects the state after the whole transaction
        for (int k = 0; k < n; k++)
            res[k].wanted_list = wanted_next(st);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short pauses, a few long ones
    function automatic int pause_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Next word of an ascending list: repeats, small and large steps, saturating at the top
    function automatic logic [ssm_pkg::WORD_W-1:0] next_word(
        inout logic [ssm_pkg::WORD_W-1:0] last);
        logic [ssm_pkg::WORD_W:0] sum;
        if ($urandom_range(0, 3) == 0)
            return last;
        sum = {1'b0, last} + 33'($urandom_range(1, 1 << $urandom_range(0, 30)));
        last = sum[ssm_pkg::WORD_W] ? {ssm_pkg::WORD_W{1'b1}} : sum[ssm_pkg::WORD_W-1:0];
        return last;
    endfunction

    // Mostly extend past what has been taken; sometimes shrink below it (list ends at
    // once), the maximum, an oversized value, or zero
    function automatic logic [ssm_pkg::BEATS_W-1:0] pick_length(
        input logic [ssm_pkg::COUNT_W-1:0] taken);
        int r;
        int done_beats;
        r = $urandom_range(0, 99);
        done_beats = taken / ssm_pkg::WORDS_PER_BEAT;
        if (r < 70)
            return ssm_pkg::BEATS_W'(done_beats + $urandom_range(0, 2));
        if (r < 82)
            return ssm_pkg::BEATS_W'($urandom_range(0, done_beats));
        if (r < 88)
            return ssm_pkg::BEATS_W'(ssm_pkg::MAX_BEATS);
        if (r < 94)
            return ssm_pkg::BEATS_W'($urandom_range(ssm_pkg::MAX_BEATS + 1,
                                                    (1 << ssm_pkg::BEATS_W) - 1));
        return '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [ssm_pkg::WORD_W-1:0] got,
                                   input logic [ssm_pkg::WORD_W-1:0] wanted);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: %s: got 0x%h, expected 0x%h", $time, what, got, wanted);
        mismatch_count++;
    endtask

    // Register write; the block is idle whenever this is called
    task automatic write_length(input logic [0:0] index,
                                input logic [ssm_pkg::BEATS_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);     // captured at this edge
        cfg_we <= 1'b0;
        if (index == ssm_pkg::REG_LIST_ONE)
        begin
            live_state.beats_one = value;
            plan_state.beats_one = value;
        end
        else
        begin
            live_state.beats_two = value;
            plan_state.beats_two = value;
        end
    endtask

    task automatic queue_word(input logic src, input logic [ssm_pkg::WORD_W-1:0] word);
        ssm_pkg::result_t unused [2];
        int               cnt;
        merge_step(plan_state, src, word, unused, cnt);
        word_queue.push_back('{src: src, word: word});
        queued_count++;
    endtask

    // Sender holds off until everything queued is sent and every result is back, then
    // allows for words that produced no result but may still be in flight
    task automatic wait_idle();
        do
            @(negedge clk);
        while (word_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One length setting: well-formed ascending lists in the order the block asks for,
    // with some random out-of-turn noise mixed in
    task automatic random_phase();
        logic [ssm_pkg::BEATS_W-1:0] len_one;
        logic [ssm_pkg::BEATS_W-1:0] len_two;
        logic [1:0]                  want;
        int                          fed;
        len_one = pick_length(plan_state.taken_one);
        len_two = pick_length(plan_state.taken_two);
        if ($urandom_range(0, 1))
        begin
            write_length(ssm_pkg::REG_LIST_ONE, len_one);
            write_length(ssm_pkg::REG_LIST_TWO, len_two);
        end
        else
        begin
            write_length(ssm_pkg::REG_LIST_TWO, len_two);
            write_length(ssm_pkg::REG_LIST_ONE, len_one);
        end
        // A base shared one time in four makes cross-list ties common
        last_one = $urandom() >> $urandom_range(0, 31);
        last_two = ($urandom_range(0, 3) == 0) ? last_one : $urandom() >> $urandom_range(0, 31);
        fed = 0;
        while (fed < PHASE_CAP && queued_count < ITEM_TARGET)
        begin
            want = wanted_next(plan_state);
            if (want == ssm_pkg::WANT_NONE || $urandom_range(0, 99) < 8)
            begin
                queue_word(1'($urandom_range(0, 1)), $urandom());
                if (want == ssm_pkg::WANT_NONE && $urandom_range(0, 1))
                    break;
            end
            else if (want == ssm_pkg::WANT_ONE)
                queue_word(ssm_pkg::LIST_ONE, next_word(last_one));
            else
                queue_word(ssm_pkg::LIST_TWO, next_word(last_two));
            fed++;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        live_state = '0;
        plan_state = '0;
        last_one   = '0;
        last_two   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty lists: everything rejected, nothing wanted
        write_length(ssm_pkg::REG_LIST_ONE, '0);
        write_length(ssm_pkg::REG_LIST_TWO, '0);
        queue_word(ssm_pkg::LIST_ONE, 32'h0000_0000);
        queue_word(ssm_pkg::LIST_TWO, 32'hFFFF_FFFF);
        wait_idle();

        // Oversized length on list one; occupied head, ties, extreme words
        write_length(ssm_pkg::REG_LIST_ONE, {ssm_pkg::BEATS_W{1'b1}});
        write_length(ssm_pkg::REG_LIST_TWO, ssm_pkg::BEATS_W'(1));
        queue_word(ssm_pkg::LIST_ONE, 32'd5);
        queue_word(ssm_pkg::LIST_ONE, 32'd6);            // head one still occupied
        queue_word(ssm_pkg::LIST_TWO, 32'd5);            // tie, list one goes first
        queue_word(ssm_pkg::LIST_ONE, 32'hFFFF_FFFF);
        queue_word(ssm_pkg::LIST_TWO, 32'h0000_0000);
        queue_word(ssm_pkg::LIST_TWO, 32'hFFFF_FFFF);    // tie at the top of the range
        wait_idle();

        // Shrink list one mid-merge: it is done at once, head two waits, nothing wanted
        write_length(ssm_pkg::REG_LIST_ONE, '0);
        queue_word(ssm_pkg::LIST_ONE, 32'd1);
        queue_word(ssm_pkg::LIST_TWO, 32'd1);
        wait_idle();

        // Reopen list one; its last word also releases the waiting head two
        write_length(ssm_pkg::REG_LIST_ONE, ssm_pkg::BEATS_W'(1));
        for (int i = 0; i < 14; i++)
            queue_word(ssm_pkg::LIST_ONE, 32'(100 + 3 * i));
        wait_idle();

        while (queued_count < ITEM_TARGET)
            random_phase();

        wait_idle();
        if (mismatch_count == 0)
            $display("sorted_stream_merge verification clean");
        else
            $display("sorted_stream_merge verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: predicts on every accepted transaction, then presents the next
    // queued word, now and then after a random gap
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        word_item_t       item;
        ssm_pkg::result_t produced [2];
        int               produced_count;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                merge_step(live_state, s_axis_tuser[0], s_axis_tdata[ssm_pkg::WORD_W-1:0],
                           produced, produced_count);
                for (int k = 0; k < produced_count; k++)
                    expected_results.push_back(produced[k]);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (word_queue.size() != 0)
                begin
                    item = word_queue.pop_front();
                    s_axis_tdata  <= ssm_pkg::IN_DATA_W'(item.word);
                    s_axis_tuser  <= item.src;
                    s_axis_tvalid <= 1'b1;
                    // Back-to-back stretches now and then, otherwise occasional gaps
                    if (send_steady > 0)
                        send_steady--;
                    else if ($urandom_range(0, 99) < 3)
                        send_steady = $urandom_range(20, 80);
                    else if ($urandom_range(0, 99) < 25)
                        send_gap = pause_length();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor and back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ssm_pkg::result_t want_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected merged transaction",
                                    m_axis_tdata[ssm_pkg::WORD_W-1:0], '0);
                else
                begin
                    want_r = expected_results.pop_front();
                    if (m_axis_tdata[ssm_pkg::WORD_W-1:0] !== want_r.merged_value)
                        report_mismatch("merged_value", m_axis_tdata[ssm_pkg::WORD_W-1:0],
                                        want_r.merged_value);
                    if (m_axis_tdata[ssm_pkg::WORD_W+1:ssm_pkg::WORD_W] !== want_r.wanted_list)
                        report_mismatch("wanted_list",
                                        32'(m_axis_tdata[ssm_pkg::WORD_W+1:ssm_pkg::WORD_W]),
                                        32'(want_r.wanted_list));
                    if (m_axis_tuser[0] !== want_r.from_list)
                        report_mismatch("from_list", 32'(m_axis_tuser[0]),
                                        32'(want_r.from_list));
                    if (m_axis_tuser[1] !== want_r.status)
                        report_mismatch("status", 32'(m_axis_tuser[1]), 32'(want_r.status));
                    if (m_axis_tlast !== want_r.final_word)
                        report_mismatch("final_word", 32'(m_axis_tlast),
                                        32'(want_r.final_word));
                end
            end

            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_steady > 0)
            begin
                recv_steady--;
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 4)
            begin
                recv_steady = $urandom_range(20, 100);
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 18)
            begin
                recv_hold = pause_length() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_stream_merge verification failed");
            $finish;
        end
    end

endmodule
